### design/button_click_long_press_detector_top_assert.svh
`ifndef BUTTON_CLICK_LONG_PRESS_DETECTOR_TOP_ASSERT_SVH
`define BUTTON_CLICK_LONG_PRESS_DETECTOR_TOP_ASSERT_SVH

`ifndef SYNTH
`define BCLP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bclp assertion failed");
`define BCLP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bclp assertion failed");
`else
`define BCLP_ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define BCLP_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

### design/bclp_pkg.sv
package bclp_pkg;

  localparam int NUM_BUTTONS = 16;
  localparam int TICK_BITS   = 32;
  localparam int CFG_W       = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LONG_PRESS = 2'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd500;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] button_bits;
    logic [TICK_BITS-1:0]   time_now;
    logic                   link_up;
  } sample_t;

  typedef struct packed {
    logic                   valid_res;
    logic [NUM_BUTTONS-1:0] held_mask;
    logic [NUM_BUTTONS-1:0] press_edge_mask;
    logic [NUM_BUTTONS-1:0] release_edge_mask;
    logic [NUM_BUTTONS-1:0] click_mask;
    logic [NUM_BUTTONS-1:0] long_mask;
  } result_t;

  typedef struct packed {
    logic                 take;
    logic [TICK_BITS-1:0] time_now;
    logic [CFG_W-1:0]     long_press_ticks;
  } lane_ctl_t;

  typedef struct packed {
    logic long_hit;
    logic click;
  } lane_res_t;

endpackage

### design/bclp_lane.sv
module bclp_lane (
  input  logic                clk,
  input  bclp_pkg::lane_ctl_t ctl,
  input  logic                btn,
  input  logic                last,
  output bclp_pkg::lane_res_t res
);

  logic [bclp_pkg::TICK_BITS-1:0] press_start;
  logic [bclp_pkg::TICK_BITS-1:0] start_eff;
  logic [bclp_pkg::TICK_BITS-1:0] held_for;
  logic                           reached;
  logic                           pressed_now;

  assign pressed_now = btn && !last;
  assign start_eff   = pressed_now ? ctl.time_now : press_start;
  assign held_for    = ctl.time_now - start_eff;
  assign reached     = held_for >=
      {{(bclp_pkg::TICK_BITS-bclp_pkg::CFG_W){1'b0}}, ctl.long_press_ticks};

  assign res.long_hit = btn && reached;
  assign res.click    = !btn && last && !reached;

  // capture press start on a rising edge of the debounced button
  always_ff @(posedge clk) begin
    if (ctl.take && pressed_now) begin
      press_start <= ctl.time_now;
    end
  end

endmodule

### design/button_click_long_press_detector_top.sv
// Button click and long-press detector. Takes sample requests and returns
// one result per sample: the sample is registered, all sixteen per-button
// hold-time compares run in parallel lanes, and the result is registered.
// Throughput is one sample a cycle unless stalled, set by the single
// input-to-result pass through the lane compares. Configuration writes are
// always accepted and should be made while idle.
`include "button_click_long_press_detector_top_assert.svh"

module button_click_long_press_detector_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  bclp_pkg::sample_t                   sample,
  output logic                                result_valid,
  input  logic                                result_stall,
  output bclp_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bclp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [bclp_pkg::CFG_W-1:0]          cfg_data
);

  logic [bclp_pkg::CFG_W-1:0]       debounce_ticks;
  logic [bclp_pkg::CFG_W-1:0]       long_press_ticks;
  logic                             stage_valid;
  bclp_pkg::sample_t                stage;
  logic [bclp_pkg::NUM_BUTTONS-1:0] last_buttons;
  logic [bclp_pkg::NUM_BUTTONS-1:0] long_state;
  logic [bclp_pkg::TICK_BITS-1:0]   last_sample_time;

  logic                             advance;
  logic                             take;
  logic [bclp_pkg::TICK_BITS-1:0]   since_last;
  bclp_pkg::lane_ctl_t              lane_ctl;
  bclp_pkg::lane_res_t              lane_res [bclp_pkg::NUM_BUTTONS];
  logic [bclp_pkg::NUM_BUTTONS-1:0] long_hits;
  logic [bclp_pkg::NUM_BUTTONS-1:0] clicks;
  bclp_pkg::result_t                result_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= bclp_pkg::DEBOUNCE_RESET;
      long_press_ticks <= bclp_pkg::LONG_PRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == bclp_pkg::CFG_DEBOUNCE) begin
        debounce_ticks <= cfg_data;
      end else if (cfg_index == bclp_pkg::CFG_LONG_PRESS) begin
        long_press_ticks <= cfg_data;
      end
    end
  end

  assign advance      = stage_valid && (!result_valid || !result_stall);
  assign sample_stall = stage_valid && !advance;

  // hold the request until the result register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!sample_stall) begin
      stage_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      stage <= sample;
    end
  end

  assign since_last = stage.time_now - last_sample_time;
  assign take = stage.link_up &&
      (since_last >= {{(bclp_pkg::TICK_BITS-bclp_pkg::CFG_W){1'b0}}, debounce_ticks});

  assign lane_ctl.take             = advance && take;
  assign lane_ctl.time_now         = stage.time_now;
  assign lane_ctl.long_press_ticks = long_press_ticks;

  for (genvar i = 0; i < bclp_pkg::NUM_BUTTONS; i++) begin : g_lane
    bclp_lane u_lane (
      .clk  (clk),
      .ctl  (lane_ctl),
      .btn  (stage.button_bits[i]),
      .last (last_buttons[i]),
      .res  (lane_res[i])
    );
    assign long_hits[i] = lane_res[i].long_hit;
    assign clicks[i]    = lane_res[i].click;
  end

  always_comb begin
    result_next = '0;
    if (stage.link_up) begin
      result_next.valid_res = 1'b1;
      if (take) begin
        result_next.held_mask         = stage.button_bits;
        result_next.press_edge_mask   = stage.button_bits & ~last_buttons;
        result_next.release_edge_mask = ~stage.button_bits & last_buttons;
        result_next.click_mask        = clicks;
        result_next.long_mask         = long_hits;
      end else begin
        result_next.held_mask = last_buttons;
        result_next.long_mask = long_state;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_buttons     <= '0;
      long_state       <= '0;
      last_sample_time <= '0;
    end else if (advance) begin
      if (!stage.link_up) begin
        last_buttons <= '0;
        long_state   <= '0;
      end else if (take) begin
        last_buttons     <= stage.button_bits;
        long_state       <= long_hits;
        last_sample_time <= stage.time_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  `BCLP_ASSERT_IMPLIES(a_edges_disjoint, clk, rst, result_valid,
      (result.press_edge_mask & result.release_edge_mask) == '0)
  `BCLP_ASSERT_IMPLIES(a_click_on_release, clk, rst, result_valid,
      (result.click_mask & ~result.release_edge_mask) == '0)
  `BCLP_ASSERT_IMPLIES(a_long_is_held, clk, rst, result_valid,
      (result.long_mask & ~result.held_mask) == '0)
  `BCLP_ASSERT_IMPLIES(a_link_down_clear, clk, rst, result_valid && !result.valid_res,
      result.held_mask == '0 && result.long_mask == '0)
  `BCLP_ASSERT_NEXT(a_down_clears_state, clk, rst, advance && !stage.link_up,
      last_buttons == '0 && long_state == '0)

endmodule
